[hw/rtl/ostt_pkg.sv]
// Package for the one-shot timer table.
// Holds the command and response payload types and the operation codes.
// No dependencies.
package ostt_pkg;

  localparam int TimeW    = 48;
  localparam int DelayW   = 40;
  localparam int ElapsedW = 32;
  localparam int SlotW    = 4;

  typedef enum logic [1:0] {
    OP_SCHEDULE = 2'd0,
    OP_CANCEL   = 2'd1,
    OP_POLL     = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]          op;
    logic [SlotW-1:0]    slot;
    logic [DelayW-1:0]   delay_us;
    logic [ElapsedW-1:0] elapsed_us;
  } cmd_t;

  typedef struct packed {
    logic             fired;
    logic [SlotW-1:0] fired_slot;
    logic             none_active;
    logic [TimeW-1:0] wait_us;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

endpackage

[hw/rtl/one_shot_timer_table.sv]
// One-shot timer table: microsecond clock, slot deadlines in a synchronous
// memory, armed flags in flip-flops, earliest-deadline scan on each poll.
// Depends on ostt_pkg.
//
//  channel | direction | handshake               | payload
//  cmd     | in        | cmd_valid / cmd_ready   | cmd_t (op, slot, delay_us, elapsed_us)
//  rsp     | out       | rsp_valid / rsp_ready   | rsp_t (fired, fired_slot, none_active,
//          |           |                         |        wait_us)
//
// Schedule and cancel do not leave the idle state; the deadline is written to memory
// in the transfer cycle. A poll advances the clock in its transfer cycle, reads
// one deadline per slot in the scan state, drains the read latency in the drain
// state, and decides and loads the response register in the final state.
// Reset is synchronous and clears the clock, the armed flags and the control;
// the deadline memory is not cleared. A new command is taken while a response
// waits; a poll that finishes while the response register is full holds in
// its final state until the response is taken.
module one_shot_timer_table
  import ostt_pkg::*;
#(
  parameter int TIMER_SLOTS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int IdxW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TIMER_SLOTS - 1);

  state_t state;
  state_t state_next;

  logic [TimeW-1:0]       now_us;
  logic [TIMER_SLOTS-1:0] armed;
  logic [TimeW-1:0]       deadline_mem [TIMER_SLOTS];

  logic [IdxW-1:0]  scan_idx;
  logic [IdxW-1:0]  rd_idx;
  logic             rd_v;
  logic             rd_armed;
  logic [TimeW-1:0] rd_data;

  logic             found;
  logic [IdxW-1:0]  best_idx;
  logic [TimeW-1:0] best_dl;

  logic              cmd_xfer;
  logic              slot_ok;
  logic [IdxW-1:0]   slot_addr;
  logic [IdxW+SlotW-1:0] slot_ext;
  logic [IdxW+SlotW-1:0] best_ext;
  logic [TimeW:0]    sched_sum;
  logic [TimeW-1:0]  sched_dl;
  logic [TimeW:0]    poll_sum;
  logic              fin_go;
  logic              fire;
  logic              take;

  // Decode the command slot
  assign cmd_ready = (state == S_IDLE);
  assign cmd_xfer  = cmd_valid && cmd_ready;
  assign slot_ext  = {{IdxW{1'b0}}, cmd.slot};
  assign slot_addr = slot_ext[IdxW-1:0];
  assign slot_ok   = ({{IdxW{1'b0}}, cmd.slot} < (IdxW + SlotW)'(TIMER_SLOTS));

  // Saturating sums for the new deadline and the advanced clock
  assign sched_sum = {1'b0, now_us} + (TimeW + 1)'(cmd.delay_us);
  assign sched_dl  = sched_sum[TimeW] ? {TimeW{1'b1}} : sched_sum[TimeW-1:0];
  assign poll_sum  = {1'b0, now_us} + (TimeW + 1)'(cmd.elapsed_us);

  // Final decision of a poll
  assign take   = rsp_valid && rsp_ready;
  assign fin_go = (state == S_FIN) && (!rsp_valid || take);
  assign fire   = found && (best_dl <= now_us);
  assign best_ext = {{SlotW{1'b0}}, best_idx};

  // Sequence the poll
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_xfer && cmd.op == OP_POLL) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (scan_idx == LastIdx) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_FIN;
      S_FIN: begin
        if (fin_go) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Deadline memory: written by schedule, read once a cycle by the scan
  always_ff @(posedge clk) begin
    if (cmd_xfer && cmd.op == OP_SCHEDULE && slot_ok) begin
      deadline_mem[slot_addr] <= sched_dl;
    end
    rd_data <= deadline_mem[scan_idx];
  end

  // Advance the scan address and tag the read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_v     <= 1'b0;
    end else begin
      rd_v <= (state == S_SCAN);
      if (state == S_SCAN) begin
        scan_idx <= (scan_idx == LastIdx) ? '0 : scan_idx + IdxW'(1);
      end else begin
        scan_idx <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx   <= scan_idx;
    rd_armed <= armed[scan_idx];
  end

  // Keep the earliest armed deadline; strict compare keeps the lowest slot
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd_xfer) begin
      found <= 1'b0;
    end else if (rd_v && rd_armed && (!found || rd_data < best_dl)) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v && rd_armed && (!found || rd_data < best_dl)) begin
      best_idx <= rd_idx;
      best_dl  <= rd_data;
    end
  end

  // Clock: advance on poll, saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      now_us <= '0;
    end else if (cmd_xfer && cmd.op == OP_POLL) begin
      now_us <= poll_sum[TimeW] ? {TimeW{1'b1}} : poll_sum[TimeW-1:0];
    end
  end

  // Armed flags: set by schedule, drop on cancel or on firing
  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= '0;
    end else begin
      if (cmd_xfer && slot_ok && cmd.op == OP_SCHEDULE) armed[slot_addr] <= 1'b1;
      if (cmd_xfer && slot_ok && cmd.op == OP_CANCEL)   armed[slot_addr] <= 1'b0;
      if (fin_go && fire) armed[best_idx] <= 1'b0;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fin_go) begin
      rsp_valid <= 1'b1;
    end else if (take) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      rsp.fired       <= fire;
      rsp.fired_slot  <= fire ? best_ext[SlotW-1:0] : '0;
      rsp.none_active <= !found;
      rsp.wait_us     <= (found && !fire) ? (best_dl - now_us) : '0;
    end
  end

  // Checks
  a_rsp_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.fired && rsp.none_active))
    else $error("response both fired and none_active");

  a_fired_no_wait: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.fired || rsp.none_active)) |-> (rsp.wait_us == '0))
    else $error("wait reported with fired or empty table");

  a_fire_disarms: assert property (@(posedge clk) disable iff (rst)
    (fin_go && fire) |=> !armed[$past(best_idx)])
    else $error("fired slot still armed");

  a_clock_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (now_us >= $past(now_us)))
    else $error("clock went backwards");

  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_v |-> (state == S_SCAN || state == S_DRAIN))
    else $error("scan read outside poll");

endmodule
